// ----- design/htc_pkg.sv -----
// htc_pkg: shared types, widths and reset constants of the heading turn controller
// used by the channel interfaces and by the top level; depends on nothing

package htc_pkg;

  localparam int unsigned AngleW    = 32;
  localparam int unsigned RateW     = 32;
  localparam int unsigned TimeW     = 32;
  localparam int unsigned DriveW    = 16;
  localparam int unsigned DeltaW    = 18;
  localparam int unsigned GainW     = 16;
  localparam int unsigned MaxTurnW  = 15;
  localparam int unsigned ThreshW   = 16;
  localparam int unsigned CfgIndexW = 3;
  localparam int unsigned CfgDataW  = 32;
  localparam int unsigned MagShift  = 9;

  localparam logic REQ_START  = 1'b0;
  localparam logic REQ_SAMPLE = 1'b1;

  typedef enum logic [1:0] {
    TM_FWD_PIVOT = 2'd0,
    TM_BWD_PIVOT = 2'd1,
    TM_SPIN      = 2'd2
  } turn_mode_e;

  typedef enum logic [CfgIndexW-1:0] {
    CFG_ANGLE_DELTA    = 3'd0,
    CFG_LINEAR_DRIVE   = 3'd1,
    CFG_TURN_MODE      = 3'd2,
    CFG_TIMEOUT_MS     = 3'd3,
    CFG_P_GAIN         = 3'd4,
    CFG_D_GAIN         = 3'd5,
    CFG_MAX_TURN       = 3'd6,
    CFG_DONE_THRESHOLD = 3'd7
  } cfg_index_e;

  localparam logic [DeltaW-1:0]   RstAngleDelta   = '0;
  localparam logic [DriveW-1:0]   RstLinearDrive  = '0;
  localparam logic [1:0]          RstTurnMode     = TM_SPIN;
  localparam logic [TimeW-1:0]    RstTimeoutMs    = '1;
  localparam logic [GainW-1:0]    RstPGain        = 16'd1311;
  localparam logic [GainW-1:0]    RstDGain        = 16'd66;
  localparam logic [MaxTurnW-1:0] RstMaxTurn      = 15'd13107;
  localparam logic [ThreshW-1:0]  RstDoneThresh   = 16'd512;

endpackage

// ----- design/htc_if.sv -----
// htc_if: valid/ready channel interfaces for requests, results and register writes
// depends on htc_pkg for field widths

interface htc_req_if
  import htc_pkg::*;
;
  logic                     valid;
  logic                     ready;
  logic                     req_type;
  logic signed [AngleW-1:0] heading;
  logic signed [RateW-1:0]  yaw_rate;
  logic [TimeW-1:0]         time_ms;

  modport source (output valid, req_type, heading, yaw_rate, time_ms, input ready);
  modport sink   (input valid, req_type, heading, yaw_rate, time_ms, output ready);
endinterface

interface htc_rsp_if
  import htc_pkg::*;
;
  logic                     valid;
  logic                     ready;
  logic signed [DriveW-1:0] left_drive;
  logic signed [DriveW-1:0] right_drive;
  logic                     drive_update;
  logic                     turn_done;

  modport source (output valid, left_drive, right_drive, drive_update, turn_done,
                  input ready);
  modport sink   (input valid, left_drive, right_drive, drive_update, turn_done,
                  output ready);
endinterface

interface htc_cfg_if
  import htc_pkg::*;
;
  logic                 valid;
  logic                 ready;
  logic [CfgIndexW-1:0] index;
  logic [CfgDataW-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- design/heading_turn_controller.sv -----
// heading_turn_controller: PD heading controller for a differential drive base
// an accepted item reaches result valid through the input, product and result registers
// throughput: one item per cycle unless the result side stalls; the product register
// splits the 32x16 multiplies from the subtract, clamp and wheel saturation
// reset: control and turn state cleared, registers back to their defaults, no clearing pass
// depends on htc_pkg and the htc_*_if interfaces

module heading_turn_controller
  import htc_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  htc_cfg_if.sink   cfg_i,
  htc_req_if.sink   req_i,
  htc_rsp_if.source rsp_o
);

  localparam int unsigned ErrW  = AngleW + 1;
  localparam int unsigned ProdW = AngleW + GainW;
  localparam int unsigned SumW  = DriveW + 1;

  typedef enum logic [1:0] {
    RK_START,
    RK_FINISH,
    RK_DRIVE
  } rsp_kind_e;

  typedef struct packed {
    rsp_kind_e        kind;
    logic             err_pos;
    logic             err_neg;
    logic [ProdW-1:0] p_term;
    logic [ProdW-1:0] d_term;
  } prod_t;

  // configuration registers
  logic signed [DeltaW-1:0] angle_delta_q;
  logic signed [DriveW-1:0] linear_drive_q;
  logic [1:0]               turn_mode_q;
  logic [TimeW-1:0]         timeout_ms_q;
  logic [GainW-1:0]         p_gain_q;
  logic [GainW-1:0]         d_gain_q;
  logic [MaxTurnW-1:0]      max_turn_q;
  logic [ThreshW-1:0]       done_thresh_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      angle_delta_q  <= RstAngleDelta;
      linear_drive_q <= RstLinearDrive;
      turn_mode_q    <= RstTurnMode;
      timeout_ms_q   <= RstTimeoutMs;
      p_gain_q       <= RstPGain;
      d_gain_q       <= RstDGain;
      max_turn_q     <= RstMaxTurn;
      done_thresh_q  <= RstDoneThresh;
    end else if (cfg_i.valid) begin
      case (cfg_index_e'(cfg_i.index))
        CFG_ANGLE_DELTA:    angle_delta_q  <= cfg_i.data[DeltaW-1:0];
        CFG_LINEAR_DRIVE:   linear_drive_q <= cfg_i.data[DriveW-1:0];
        CFG_TURN_MODE:      turn_mode_q    <= cfg_i.data[1:0];
        CFG_TIMEOUT_MS:     timeout_ms_q   <= cfg_i.data[TimeW-1:0];
        CFG_P_GAIN:         p_gain_q       <= cfg_i.data[GainW-1:0];
        CFG_D_GAIN:         d_gain_q       <= cfg_i.data[GainW-1:0];
        CFG_MAX_TURN:       max_turn_q     <= cfg_i.data[MaxTurnW-1:0];
        CFG_DONE_THRESHOLD: done_thresh_q  <= cfg_i.data[ThreshW-1:0];
        default: ;
      endcase
    end
  end

  // pipeline flow control
  logic in_valid_q, prod_valid_q, out_valid_q;
  logic out_en, prod_en, in_en;

  assign out_en     = !out_valid_q || rsp_o.ready;
  assign prod_en    = !prod_valid_q || out_en;
  assign in_en      = !in_valid_q || prod_en;
  assign req_i.ready = in_en;

  // input register
  logic                     in_type_q;
  logic signed [AngleW-1:0] in_heading_q;
  logic signed [RateW-1:0]  in_rate_q;
  logic [TimeW-1:0]         in_time_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_en) begin
      in_valid_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_en && req_i.valid) begin
      in_type_q    <= req_i.req_type;
      in_heading_q <= req_i.heading;
      in_rate_q    <= req_i.yaw_rate;
      in_time_q    <= req_i.time_ms;
    end
  end

  // turn state and decision
  logic [AngleW-1:0] target_q, target_d;
  logic [TimeW-1:0]  start_q, start_d;
  logic              done_q, done_d;
  logic signed [ErrW-1:0] err;
  logic [AngleW-1:0]  aerr;
  logic [RateW-1:0]   arate;
  logic [TimeW-1:0]   elapsed;
  logic               finish;
  prod_t              prod_d, prod_q;
  logic               in_adv;

  assign in_adv = in_valid_q && prod_en;

  always_comb begin
    err     = $signed({in_heading_q[AngleW-1], in_heading_q})
            - $signed({target_q[AngleW-1], target_q});
    aerr    = err[ErrW-1] ? AngleW'(-err) : err[AngleW-1:0];
    arate   = in_rate_q[RateW-1] ? RateW'(-in_rate_q) : RateW'(in_rate_q);
    elapsed = in_time_q - start_q;
    finish  = done_q || (aerr < AngleW'(done_thresh_q)) || (elapsed > timeout_ms_q);

    target_d = target_q;
    start_d  = start_q;
    done_d   = done_q;

    prod_d.err_pos = !err[ErrW-1] && (err != '0);
    prod_d.err_neg = err[ErrW-1];
    prod_d.p_term  = aerr * p_gain_q;
    prod_d.d_term  = arate * d_gain_q;

    if (in_type_q == REQ_START) begin
      prod_d.kind = RK_START;
      target_d    = in_heading_q + AngleW'(angle_delta_q);
      start_d     = in_time_q;
      done_d      = 1'b0;
    end else if (finish) begin
      prod_d.kind = RK_FINISH;
      done_d      = 1'b1;
    end else begin
      prod_d.kind = RK_DRIVE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q     <= '0;
      start_q      <= '0;
      done_q       <= 1'b0;
      prod_valid_q <= 1'b0;
    end else begin
      if (in_adv) begin
        target_q <= target_d;
        start_q  <= start_d;
        done_q   <= done_d;
      end
      if (prod_en) begin
        prod_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_adv) begin
      prod_q <= prod_d;
    end
  end

  // effort, wheel split and saturation
  logic [ProdW-1:0]          diff;
  logic [ProdW-MagShift-1:0] mag_full;
  logic [MaxTurnW-1:0]       mag;
  logic signed [DriveW-1:0]  effort;
  logic signed [DriveW-1:0]  left_e, right_e;
  logic signed [SumW-1:0]    left_sum, right_sum;
  logic signed [DriveW-1:0]  left_d, right_d, left_q, right_q;
  logic                      upd_d, upd_q, turn_done_d, turn_done_q;

  function automatic logic signed [DriveW-1:0] sat_drive(input logic signed [SumW-1:0] v);
    logic signed [SumW-1:0] hi, lo;
    hi = SumW'({1'b0, {(DriveW-1){1'b1}}});
    lo = -hi - SumW'(1);
    if (v > hi) begin
      sat_drive = hi[DriveW-1:0];
    end else if (v < lo) begin
      sat_drive = lo[DriveW-1:0];
    end else begin
      sat_drive = v[DriveW-1:0];
    end
  endfunction

  always_comb begin
    diff     = (prod_q.p_term > prod_q.d_term) ? prod_q.p_term - prod_q.d_term : '0;
    mag_full = diff[ProdW-1:MagShift];
    mag      = (mag_full > (ProdW-MagShift)'(max_turn_q)) ? max_turn_q
                                                          : mag_full[MaxTurnW-1:0];
    if (prod_q.err_pos) begin
      effort = $signed({1'b0, mag});
    end else if (prod_q.err_neg) begin
      effort = -$signed({1'b0, mag});
    end else begin
      effort = '0;
    end

    left_e  = '0;
    right_e = '0;
    case (turn_mode_q)
      TM_FWD_PIVOT: begin
        if (effort > 0) right_e = effort;
        else            left_e  = -effort;
      end
      TM_BWD_PIVOT: begin
        if (effort > 0) left_e  = -effort;
        else            right_e = effort;
      end
      default: begin
        right_e = effort;
        left_e  = -effort;
      end
    endcase

    left_sum  = SumW'(left_e) + SumW'(linear_drive_q);
    right_sum = SumW'(right_e) + SumW'(linear_drive_q);

    case (prod_q.kind)
      RK_DRIVE: begin
        left_d      = sat_drive(left_sum);
        right_d     = sat_drive(right_sum);
        upd_d       = 1'b1;
        turn_done_d = 1'b0;
      end
      RK_START: begin
        left_d      = '0;
        right_d     = '0;
        upd_d       = 1'b1;
        turn_done_d = 1'b0;
      end
      default: begin
        left_d      = '0;
        right_d     = '0;
        upd_d       = 1'b0;
        turn_done_d = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_en) begin
      out_valid_q <= prod_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_en && prod_valid_q) begin
      left_q      <= left_d;
      right_q     <= right_d;
      upd_q       <= upd_d;
      turn_done_q <= turn_done_d;
    end
  end

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.left_drive   = left_q;
  assign rsp_o.right_drive  = right_q;
  assign rsp_o.drive_update = upd_q;
  assign rsp_o.turn_done    = turn_done_q;

  // checks
  a_upd_done_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(upd_q && turn_done_q))
    else $error("drive update and turn done both set");

  a_done_zero_drive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && turn_done_q) |-> (left_q == '0 && right_q == '0))
    else $error("finished result carries a drive");

  a_start_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_adv && in_type_q == REQ_START) |=> !done_q)
    else $error("start item did not clear done flag");

  a_done_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && !(in_adv && in_type_q == REQ_START)) |=> done_q)
    else $error("done flag dropped without a start item");

  a_prod_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (prod_valid_q && !out_en) |=> prod_valid_q)
    else $error("product stage lost an item under stall");

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// testbench: self-checking bench for heading_turn_controller, directed table then random turns
// drives the request and register write channels, predicts every result, checks the result channel
// depends on htc_pkg, the htc_*_if interfaces and the heading_turn_controller top level

module testbench;
  import htc_pkg::*;

  localparam int unsigned CycleLimit = 400_000;
  localparam int unsigned RandItems  = 500;
  localparam int          DeltaLimit = 92160;
  localparam logic [1:0]  TurnModeSpare = 2'd3;

  typedef struct packed {
    logic                     req_type;
    logic signed [AngleW-1:0] heading;
    logic signed [RateW-1:0]  yaw_rate;
    logic [TimeW-1:0]         time_ms;
  } req_item_t;

  typedef struct packed {
    logic signed [DriveW-1:0] left_drive;
    logic signed [DriveW-1:0] right_drive;
    logic                     drive_update;
    logic                     turn_done;
  } drive_cmd_t;

  typedef enum logic [1:0] {
    ROW_CFG,
    ROW_ITEM,
    ROW_ITEM_EXP
  } row_kind_e;

  typedef struct packed {
    row_kind_e           kind;
    cfg_index_e          reg_index;
    logic [CfgDataW-1:0] reg_data;
    req_item_t           item;
    drive_cmd_t          cmd;
  } stim_row_t;

  localparam drive_cmd_t StartCmd = '{16'sd0, 16'sd0, 1'b1, 1'b0};
  localparam drive_cmd_t DoneCmd  = '{16'sd0, 16'sd0, 1'b0, 1'b1};
  localparam drive_cmd_t NoCmd    = '0;
  localparam req_item_t  NoItem   = '0;
  localparam cfg_index_e NoReg    = CFG_ANGLE_DELTA;

  localparam int NRows = 40;
  localparam stim_row_t DirRows [NRows] = '{
    '{ROW_CFG, CFG_ANGLE_DELTA, 32'sd92160, NoItem, NoCmd},
    // sample before any start, then sticky done
    '{ROW_ITEM_EXP, NoReg, '0, '{REQ_SAMPLE, 32'sd0, 32'sd0, 32'd0}, DoneCmd},
    '{ROW_ITEM_EXP, NoReg, '0, '{REQ_SAMPLE, 32'sd1000000, 32'sd0, 32'd5}, DoneCmd},
    '{ROW_ITEM_EXP, NoReg, '0, '{REQ_START, 32'sd0, 32'sd0, 32'd100}, StartCmd},
    '{ROW_ITEM, NoReg, '0, '{REQ_SAMPLE, 32'sd0, 32'sd0, 32'd101}, NoCmd},
    '{ROW_ITEM, NoReg, '0, '{REQ_SAMPLE, 32'sh7FFFFFFF, 32'sh80000000, 32'd102}, NoCmd},
    '{ROW_ITEM, NoReg, '0, '{REQ_SAMPLE, 32'sh80000000, 32'sh7FFFFFFF, 32'd103}, NoCmd},
    // error just below threshold
    '{ROW_ITEM_EXP, NoReg, '0, '{REQ_SAMPLE, 32'sd91649, 32'sd0, 32'd104}, DoneCmd},
    '{ROW_ITEM_EXP, NoReg, '0, '{REQ_SAMPLE, 32'sd0, 32'sd0, 32'd105}, DoneCmd},
    '{ROW_CFG, CFG_TURN_MODE, 32'(TM_FWD_PIVOT), NoItem, NoCmd},
    '{ROW_CFG, CFG_LINEAR_DRIVE, 32'sd32767, NoItem, NoCmd},
    '{ROW_CFG, CFG_MAX_TURN, 32'd32767, NoItem, NoCmd},
    '{ROW_CFG, CFG_TIMEOUT_MS, 32'd1000, NoItem, NoCmd},
    // target wraps, time wraps
    '{ROW_ITEM_EXP, NoReg, '0, '{REQ_START, 32'sh7FFFFFFF, 32'sd0, 32'hFFFFFF00}, StartCmd},
    '{ROW_ITEM, NoReg, '0, '{REQ_SAMPLE, 32'sh7FFFFFFF, 32'sd0, 32'hFFFFFF10}, NoCmd},
    '{ROW_ITEM, NoReg, '0, '{REQ_SAMPLE, 32'sd0, -32'sd5000, 32'h10}, NoCmd},
    '{ROW_ITEM, NoReg, '0, '{REQ_SAMPLE, 32'sh80000000, 32'sd1000, 32'h20}, NoCmd},
    '{ROW_ITEM, NoReg, '0, '{REQ_SAMPLE, 32'sd0, 32'sd0, 32'd744}, NoCmd},
    '{ROW_ITEM_EXP, NoReg, '0, '{REQ_SAMPLE, 32'sd0, 32'sd0, 32'd745}, DoneCmd},
    '{ROW_CFG, CFG_TURN_MODE, 32'(TM_BWD_PIVOT), NoItem, NoCmd},
    '{ROW_CFG, CFG_LINEAR_DRIVE, -32'sd32768, NoItem, NoCmd},
    '{ROW_CFG, CFG_ANGLE_DELTA, -32'sd92160, NoItem, NoCmd},
    '{ROW_CFG, CFG_P_GAIN, 32'd65535, NoItem, NoCmd},
    '{ROW_CFG, CFG_D_GAIN, 32'd65535, NoItem, NoCmd},
    '{ROW_CFG, CFG_DONE_THRESHOLD, 32'd0, NoItem, NoCmd},
    '{ROW_CFG, CFG_TIMEOUT_MS, 32'hFFFFFFFF, NoItem, NoCmd},
    '{ROW_ITEM_EXP, NoReg, '0, '{REQ_START, 32'sd0, 32'sd0, 32'd0}, StartCmd},
    '{ROW_ITEM, NoReg, '0, '{REQ_SAMPLE, 32'sd0, 32'sd0, 32'd1}, NoCmd},
    '{ROW_ITEM, NoReg, '0, '{REQ_SAMPLE, -32'sd93160, 32'sd0, 32'd2}, NoCmd},
    // zero error with zero threshold
    '{ROW_ITEM, NoReg, '0, '{REQ_SAMPLE, -32'sd92160, 32'sd0, 32'd3}, NoCmd},
    '{ROW_ITEM, NoReg, '0, '{REQ_SAMPLE, 32'sd0, 32'sh7FFFFFFF, 32'd4}, NoCmd},
    '{ROW_CFG, CFG_TURN_MODE, 32'(TurnModeSpare), NoItem, NoCmd},
    '{ROW_CFG, CFG_MAX_TURN, 32'd0, NoItem, NoCmd},
    '{ROW_CFG, CFG_DONE_THRESHOLD, 32'd65535, NoItem, NoCmd},
    '{ROW_CFG, CFG_P_GAIN, 32'd0, NoItem, NoCmd},
    '{ROW_CFG, CFG_D_GAIN, 32'd0, NoItem, NoCmd},
    '{ROW_CFG, CFG_LINEAR_DRIVE, 32'd0, NoItem, NoCmd},
    '{ROW_ITEM_EXP, NoReg, '0, '{REQ_START, 32'sd1000000, 32'sd0, 32'd0}, StartCmd},
    '{ROW_ITEM, NoReg, '0, '{REQ_SAMPLE, 32'sd0, 32'sd0, 32'd1}, NoCmd},
    '{ROW_ITEM_EXP, NoReg, '0, '{REQ_SAMPLE, 32'sd973374, 32'sd0, 32'd2}, DoneCmd}
  };

  logic clk;
  logic rst_n;

  htc_cfg_if cfg_if ();
  htc_req_if req_if ();
  htc_rsp_if rsp_if ();

  heading_turn_controller dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .cfg_i (cfg_if),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  // predictor copy of registers and turn state
  logic [DeltaW-1:0]        m_delta;
  logic signed [DriveW-1:0] m_fwd_bias;
  logic [1:0]               m_mode;
  logic [TimeW-1:0]         m_abort_ms;
  logic [GainW-1:0]         m_p_gain;
  logic [GainW-1:0]         m_d_gain;
  logic [MaxTurnW-1:0]      m_max_turn;
  logic [ThreshW-1:0]       m_thresh;
  logic [AngleW-1:0]        hdg_target;
  logic [TimeW-1:0]         t_start;
  logic                     turn_over;

  drive_cmd_t  pending_cmds [$];
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  int unsigned burst_left = 0;
  logic [15:0] stall_pat = 16'hFFFF;
  logic [3:0]  pat_pos = '0;

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  function automatic logic signed [DriveW-1:0] clamp_q15(int v);
    if (v > 32767) return 16'sh7FFF;
    if (v < -32768) return 16'sh8000;
    return 16'(v);
  endfunction

  function automatic void apply_reg(cfg_index_e idx, logic [CfgDataW-1:0] data);
    case (idx)
      CFG_ANGLE_DELTA:    m_delta = data[DeltaW-1:0];
      CFG_LINEAR_DRIVE:   m_fwd_bias = data[DriveW-1:0];
      CFG_TURN_MODE:      m_mode = data[1:0];
      CFG_TIMEOUT_MS:     m_abort_ms = data[TimeW-1:0];
      CFG_P_GAIN:         m_p_gain = data[GainW-1:0];
      CFG_D_GAIN:         m_d_gain = data[GainW-1:0];
      CFG_MAX_TURN:       m_max_turn = data[MaxTurnW-1:0];
      CFG_DONE_THRESHOLD: m_thresh = data[ThreshW-1:0];
      default: ;
    endcase
  endfunction

  function automatic drive_cmd_t steer_predict(req_item_t it);
    logic signed [AngleW:0] err;
    logic [AngleW:0]        err_mag;
    logic [RateW:0]         rate_mag;
    logic [TimeW-1:0]       elapsed;
    logic [63:0]            p_term;
    logic [63:0]            d_term;
    logic [63:0]            mag;
    int                     effort;
    int                     left;
    int                     right;
    drive_cmd_t             cmd;
    cmd = '0;
    if (it.req_type == REQ_START) begin
      hdg_target = it.heading + {{(AngleW-DeltaW){m_delta[DeltaW-1]}}, m_delta};
      t_start = it.time_ms;
      turn_over = 1'b0;
      cmd.drive_update = 1'b1;
      return cmd;
    end
    if (turn_over) begin
      cmd.turn_done = 1'b1;
      return cmd;
    end
    // exact 33-bit difference, no wrap
    err = {it.heading[AngleW-1], it.heading} - {hdg_target[AngleW-1], hdg_target};
    err_mag = err[AngleW] ? -err : err;
    elapsed = it.time_ms - t_start;
    if (err_mag < m_thresh || elapsed > m_abort_ms) begin
      turn_over = 1'b1;
      cmd.turn_done = 1'b1;
      return cmd;
    end
    rate_mag = it.yaw_rate[RateW-1] ? -{it.yaw_rate[RateW-1], it.yaw_rate}
                                    : {it.yaw_rate[RateW-1], it.yaw_rate};
    p_term = 64'(err_mag) * 64'(m_p_gain);
    d_term = 64'(rate_mag) * 64'(m_d_gain);
    mag = (p_term > d_term) ? ((p_term - d_term) >> MagShift) : 64'd0;
    if (mag > m_max_turn) mag = 64'(m_max_turn);
    effort = (err == 0) ? 0 : (err[AngleW] ? -int'(mag) : int'(mag));
    left = 0;
    right = 0;
    case (m_mode)
      TM_FWD_PIVOT: begin
        if (effort > 0) right = effort;
        else left = -effort;
      end
      TM_BWD_PIVOT: begin
        if (effort > 0) left = -effort;
        else right = effort;
      end
      default: begin
        right = effort;
        left = -effort;
      end
    endcase
    cmd.left_drive = clamp_q15(left + m_fwd_bias);
    cmd.right_drive = clamp_q15(right + m_fwd_bias);
    cmd.drive_update = 1'b1;
    return cmd;
  endfunction

  function automatic logic [CfgDataW-1:0] pick_reg(cfg_index_e idx);
    int unsigned sel;
    sel = $urandom_range(0, 3);
    case (idx)
      CFG_ANGLE_DELTA:
        return (sel == 0) ? -32'sd92160 : (sel == 1) ? 32'sd92160 :
               32'($urandom_range(0, 2 * DeltaLimit) - DeltaLimit);
      CFG_LINEAR_DRIVE:
        return (sel == 0) ? -32'sd32768 : (sel == 1) ? 32'sd32767 :
               (sel == 2) ? 32'd0 : 32'($urandom_range(0, 65535) - 32768);
      CFG_TURN_MODE:
        return 32'($urandom_range(0, 3));
      CFG_TIMEOUT_MS:
        return (sel == 0) ? 32'd0 : (sel == 1) ? 32'hFFFFFFFF :
               (sel == 2) ? 32'($urandom_range(0, 2000)) : 32'($urandom);
      CFG_MAX_TURN:
        return (sel == 0) ? 32'd0 : (sel == 1) ? 32'd32767 : 32'($urandom_range(0, 32767));
      CFG_DONE_THRESHOLD:
        return (sel == 0) ? 32'd0 : (sel == 1) ? 32'd65535 : 32'($urandom_range(0, 4096));
      default:
        return (sel == 0) ? 32'd0 : (sel == 1) ? 32'd65535 : 32'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // register write only once every pending result is back
  task automatic cfg_write(cfg_index_e idx, logic [CfgDataW-1:0] data);
    req_if.valid <= 1'b0;
    while (pending_cmds.size() != 0) @(posedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    do @(posedge clk); while (!cfg_if.ready);
    apply_reg(idx, data);
  endtask

  task automatic send_request(req_item_t it, bit use_typed, drive_cmd_t typed_cmd);
    int unsigned gap;
    drive_cmd_t  cmd;
    cfg_if.valid <= 1'b0;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        req_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 30);
    end
    burst_left--;
    req_if.valid     <= 1'b1;
    req_if.req_type  <= it.req_type;
    req_if.heading   <= it.heading;
    req_if.yaw_rate  <= it.yaw_rate;
    req_if.time_ms   <= it.time_ms;
    do @(posedge clk); while (!req_if.ready);
    cmd = steer_predict(it);
    pending_cmds.push_back(use_typed ? typed_cmd : cmd);
  endtask

  // result side stalls on a rotating pattern, reloaded each time the pattern position wraps
  always @(posedge clk) begin
    rsp_if.ready <= stall_pat[pat_pos];
    pat_pos <= pat_pos + 4'd1;
    if (pat_pos == 4'hF) stall_pat <= ($urandom_range(0, 2) == 0) ? 16'hFFFF : 16'($urandom);
  end

  always @(posedge clk) begin
    drive_cmd_t want;
    if (rst_n && rsp_if.valid && rsp_if.ready) begin
      if (pending_cmds.size() == 0) begin
        $display("%0t ns: result with none expected, got left %0d right %0d upd %0b done %0b",
                 $time, rsp_if.left_drive, rsp_if.right_drive, rsp_if.drive_update,
                 rsp_if.turn_done);
        mismatches++;
      end else begin
        want = pending_cmds.pop_front();
        check_field("left_drive", want.left_drive, rsp_if.left_drive);
        check_field("right_drive", want.right_drive, rsp_if.right_drive);
        check_field("drive_update", want.drive_update, rsp_if.drive_update);
        check_field("turn_done", want.turn_done, rsp_if.turn_done);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    int unsigned items_sent;
    int unsigned phase_len;
    int unsigned sel;
    int          offset;
    int          thr;
    logic [TimeW-1:0] clock_ms;
    req_item_t   it;
    items_sent = 0;
    clock_ms = '0;
    rst_n = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = CFG_ANGLE_DELTA;
    cfg_if.data = '0;
    req_if.valid = 1'b0;
    req_if.req_type = REQ_START;
    req_if.heading = '0;
    req_if.yaw_rate = '0;
    req_if.time_ms = '0;
    rsp_if.ready = 1'b0;
    m_delta = RstAngleDelta;
    m_fwd_bias = RstLinearDrive;
    m_mode = RstTurnMode;
    m_abort_ms = RstTimeoutMs;
    m_p_gain = RstPGain;
    m_d_gain = RstDGain;
    m_max_turn = RstMaxTurn;
    m_thresh = RstDoneThresh;
    hdg_target = '0;
    t_start = '0;
    turn_over = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int r = 0; r < NRows; r++) begin
      case (DirRows[r].kind)
        ROW_CFG:      cfg_write(DirRows[r].reg_index, DirRows[r].reg_data);
        ROW_ITEM:     send_request(DirRows[r].item, 1'b0, NoCmd);
        ROW_ITEM_EXP: send_request(DirRows[r].item, 1'b1, DirRows[r].cmd);
        default: ;
      endcase
    end

    // random turns: fresh registers, a start, then mostly samples scattered around the target
    while (items_sent < RandItems) begin
      for (int k = 0; k <= int'(CFG_DONE_THRESHOLD); k++)
        cfg_write(cfg_index_e'(k), pick_reg(cfg_index_e'(k)));
      phase_len = $urandom_range(8, 40);
      for (int n = 0; n < phase_len; n++) begin
        sel = $urandom_range(0, 99);
        if (n == 0 || sel < 6) begin
          clock_ms = (sel < 3) ? 32'hFFFFFFFF - $urandom_range(0, 500) : 32'($urandom);
          it.req_type = REQ_START;
          it.heading = $urandom;
          it.yaw_rate = $urandom;
          it.time_ms = clock_ms;
        end else if (sel < 14) begin
          it.req_type = 1'($urandom_range(0, 1));
          it.heading = $urandom;
          it.yaw_rate = $urandom;
          it.time_ms = $urandom;
        end else begin
          thr = int'(m_thresh);
          case ($urandom_range(0, 5))
            0, 1, 2: offset = int'($urandom_range(0, 2 * thr + 2)) - (thr + 1);
            3, 4:    offset = int'($urandom_range(0, 240000)) - 120000;
            default: offset = int'($urandom);
          endcase
          clock_ms += ($urandom_range(0, 15) == 0) ? $urandom_range(0, 5000)
                                                    : $urandom_range(0, 40);
          it.req_type = REQ_SAMPLE;
          it.heading = hdg_target + 32'(offset);
          it.yaw_rate = ($urandom_range(0, 1) == 0) ?
                        32'(int'($urandom_range(0, 100000)) - 50000) : 32'($urandom);
          it.time_ms = clock_ms;
        end
        send_request(it, 1'b0, NoCmd);
        items_sent++;
      end
    end

    req_if.valid <= 1'b0;
    while (pending_cmds.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
